// ===== rtl/core/fls_pkg.sv =====
// Shared types, constants and codes for the fuzzy logic stack evaluator.
// No dependencies; used by every module of the block but fls_ram.
package fls_pkg;

  // Stack geometry
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1);

  // Q1.16 truth values
  localparam int unsigned VAL_W  = 17;
  localparam int unsigned FRAC_W = 16;
  localparam logic [VAL_W-1:0] Q_ONE  = VAL_W'(1) << FRAC_W;
  localparam logic [VAL_W-1:0] Q_ZERO = '0;

  // Square root unit: one result bit per step
  localparam int unsigned SQRT_STEPS = VAL_W;
  localparam int unsigned SQRT_CNT_W = $clog2(SQRT_STEPS);
  localparam int unsigned REM_W      = VAL_W + 4;
  localparam int unsigned PROD_W     = 2 * VAL_W;

  typedef enum logic [2:0] {
    CMD_CLEAR      = 3'd0,
    CMD_PUSH       = 3'd1,
    CMD_AND        = 3'd2,
    CMD_OR         = 3'd3,
    CMD_NOT        = 3'd4,
    CMD_VERY       = 3'd5,
    CMD_SOMEWHAT   = 3'd6,
    CMD_GET_SCALAR = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  // Datapath operations, one per cycle
  typedef enum logic [4:0] {
    DP_NOP,
    DP_CLEAR,
    DP_PUSH,
    DP_UNDER,
    DP_OVER,
    DP_RD_TOP,
    DP_BIN_A,
    DP_BIN_WB,
    DP_NOT_WB,
    DP_MUL,
    DP_VERY_WB,
    DP_SQRT_INIT,
    DP_SQRT_STEP,
    DP_SQRT_WB,
    DP_SCAN_FIRST,
    DP_SCAN_STEP,
    DP_SCAN_TOP
  } dp_op_e;

  typedef struct packed {
    logic [2:0]       command;
    logic [VAL_W-1:0] operand;
  } fls_req_t;

  typedef struct packed {
    logic [VAL_W-1:0] value_out;
    logic [1:0]       status;
  } fls_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic   load_req;
    logic   load_out;
    dp_op_e op;
  } fls_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic lt2;
    logic empty;
    logic scan_top;
    logic sqrt_last;
  } fls_stat_t;

  function automatic logic [VAL_W-1:0] min_val(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [VAL_W-1:0] max_val(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== rtl/core/fls_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fls_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/fls_datapath.sv =====
// Datapath: stack RAM, depth counter, squarer, bit-serial square root,
// scan accumulator and output register. Depends on fls_pkg and fls_ram.
module fls_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fls_pkg::fls_req_t req_i,
  input  fls_pkg::fls_ctrl_t ctrl_i,
  output fls_pkg::fls_stat_t stat_o,
  output fls_pkg::fls_rsp_t rsp_o
);

  localparam int unsigned AW = fls_pkg::ADDR_W;
  localparam int unsigned DW = fls_pkg::DEPTH_W;
  localparam int unsigned VW = fls_pkg::VAL_W;
  localparam int unsigned FW = fls_pkg::FRAC_W;
  localparam int unsigned RW = fls_pkg::REM_W;
  localparam int unsigned PW = fls_pkg::PROD_W;
  localparam int unsigned CW = fls_pkg::SQRT_CNT_W;

  fls_pkg::fls_req_t req_q;
  fls_pkg::fls_rsp_t out_q;
  logic [DW-1:0] depth_q, depth_d;
  logic [VW-1:0] a_q, acc_q, res_q;
  fls_pkg::status_e st_q;
  logic [AW-1:0] idx_q;
  logic [PW-1:0] prod_q;
  logic [PW-1:0] x_q;
  logic [RW-1:0] rem_q, rem_next;
  logic [VW-1:0] root_q, root_next;
  logic [CW-1:0] cnt_q;

  logic [DW-1:0] top_idx, second_idx;
  logic [AW-1:0] top_addr, second_addr;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [VW-1:0] wdata, rdata, rdata_sat, sat_opnd, bin_res;
  logic [RW-1:0] rem_shift, trial;
  logic          trial_ge;
  fls_pkg::cmd_e cmd;

  assign cmd         = fls_pkg::cmd_e'(req_q.command);
  assign top_idx     = depth_q - DW'(1);
  assign second_idx  = depth_q - DW'(2);
  assign top_addr    = top_idx[AW-1:0];
  assign second_addr = second_idx[AW-1:0];
  assign rdata_sat   = fls_pkg::min_val(rdata, fls_pkg::Q_ONE);
  assign sat_opnd    = fls_pkg::min_val(req_q.operand, fls_pkg::Q_ONE);
  assign bin_res     = (cmd == fls_pkg::CMD_AND) ? fls_pkg::min_val(a_q, rdata)
                                                 : fls_pkg::max_val(a_q, rdata);

  // One square root step: bring down two bits, try to subtract
  assign rem_shift = {rem_q[RW-3:0], x_q[PW-1 -: 2]};
  assign trial     = RW'({root_q, 2'b01});
  assign trial_ge  = (rem_shift >= trial);
  assign rem_next  = trial_ge ? (rem_shift - trial) : rem_shift;
  assign root_next = {root_q[VW-2:0], trial_ge};

  // Stack RAM ports
  always_comb begin
    we    = 1'b0;
    waddr = top_addr;
    wdata = fls_pkg::Q_ZERO;
    raddr = top_addr;
    case (ctrl_i.op)
      fls_pkg::DP_PUSH: begin
        we    = 1'b1;
        waddr = depth_q[AW-1:0];
        wdata = sat_opnd;
      end
      fls_pkg::DP_BIN_A: raddr = second_addr;
      fls_pkg::DP_BIN_WB: begin
        we    = 1'b1;
        waddr = second_addr;
        wdata = bin_res;
      end
      fls_pkg::DP_NOT_WB: begin
        we    = 1'b1;
        wdata = fls_pkg::Q_ONE - rdata_sat;
      end
      fls_pkg::DP_VERY_WB: begin
        we    = 1'b1;
        wdata = prod_q[FW+VW-1:FW];
      end
      fls_pkg::DP_SQRT_WB: begin
        we    = 1'b1;
        wdata = fls_pkg::min_val(root_q, fls_pkg::Q_ONE);
      end
      fls_pkg::DP_SCAN_FIRST: raddr = '0;
      fls_pkg::DP_SCAN_STEP:  raddr = idx_q + AW'(1);
      default: ;
    endcase
  end

  fls_ram #(
    .WIDTH(VW),
    .DEPTH(fls_pkg::STACK_DEPTH)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Depth update
  always_comb begin
    depth_d = depth_q;
    case (ctrl_i.op)
      fls_pkg::DP_CLEAR:  depth_d = '0;
      fls_pkg::DP_PUSH:   depth_d = depth_q + DW'(1);
      fls_pkg::DP_BIN_WB: depth_d = top_idx;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  // Working registers and result
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_req) begin
      req_q <= req_i;
    end
    if (ctrl_i.load_out) begin
      out_q.value_out <= res_q;
      out_q.status    <= st_q;
    end
    case (ctrl_i.op)
      fls_pkg::DP_CLEAR: begin
        res_q <= fls_pkg::Q_ZERO;
        st_q  <= fls_pkg::ST_OK;
      end
      fls_pkg::DP_PUSH: begin
        res_q <= sat_opnd;
        st_q  <= fls_pkg::ST_OK;
      end
      fls_pkg::DP_UNDER: begin
        res_q <= fls_pkg::Q_ZERO;
        st_q  <= fls_pkg::ST_UNDER;
      end
      fls_pkg::DP_OVER: begin
        res_q <= fls_pkg::Q_ZERO;
        st_q  <= fls_pkg::ST_OVER;
      end
      fls_pkg::DP_BIN_A: a_q <= rdata;
      fls_pkg::DP_MUL:   prod_q <= PW'(rdata_sat) * PW'(rdata_sat);
      fls_pkg::DP_SQRT_INIT: begin
        x_q    <= PW'({rdata_sat, FW'(0)});
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= CW'(fls_pkg::SQRT_STEPS - 1);
      end
      fls_pkg::DP_SQRT_STEP: begin
        x_q    <= x_q << 2;
        rem_q  <= rem_next;
        root_q <= root_next;
        cnt_q  <= cnt_q - CW'(1);
      end
      fls_pkg::DP_BIN_WB, fls_pkg::DP_NOT_WB, fls_pkg::DP_VERY_WB,
      fls_pkg::DP_SQRT_WB: begin
        res_q <= wdata;
        st_q  <= fls_pkg::ST_OK;
      end
      fls_pkg::DP_SCAN_FIRST: begin
        acc_q <= fls_pkg::Q_ONE;
        idx_q <= '0;
      end
      fls_pkg::DP_SCAN_STEP: begin
        // Entry below the top: fold in its complement
        acc_q <= fls_pkg::min_val(acc_q, fls_pkg::Q_ONE - rdata_sat);
        idx_q <= idx_q + AW'(1);
      end
      fls_pkg::DP_SCAN_TOP: begin
        // Top entry of a scan closes the result
        res_q <= fls_pkg::min_val(acc_q, rdata);
        st_q  <= fls_pkg::ST_OK;
      end
      default: ;
    endcase
  end

  // Status back to the controller
  assign stat_o.cmd       = cmd;
  assign stat_o.full      = (depth_q >= DW'(fls_pkg::STACK_DEPTH));
  assign stat_o.lt2       = (depth_q < DW'(2));
  assign stat_o.empty     = (depth_q == '0);
  assign stat_o.scan_top  = (idx_q == top_addr);
  assign stat_o.sqrt_last = (cnt_q == '0);

  assign rsp_o = out_q;

endmodule

// ===== rtl/core/fls_ctrl.sv =====
// Controller: sequences one request at a time through the datapath and
// owns both handshakes. Depends on fls_pkg.
module fls_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  fls_pkg::fls_stat_t stat_i,
  output fls_pkg::fls_ctrl_t ctrl_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_A,
    S_RD_B,
    S_MUL,
    S_SQRT,
    S_SQRT_WB,
    S_SCAN,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and datapath command
  always_comb begin
    state_d         = state_q;
    ctrl_o.load_req = 1'b0;
    ctrl_o.load_out = 1'b0;
    ctrl_o.op       = fls_pkg::DP_NOP;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load_req = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        case (stat_i.cmd)
          fls_pkg::CMD_CLEAR: ctrl_o.op = fls_pkg::DP_CLEAR;
          fls_pkg::CMD_PUSH:
            ctrl_o.op = stat_i.full ? fls_pkg::DP_OVER : fls_pkg::DP_PUSH;
          fls_pkg::CMD_AND, fls_pkg::CMD_OR: begin
            if (stat_i.lt2) begin
              ctrl_o.op = fls_pkg::DP_UNDER;
            end else begin
              ctrl_o.op = fls_pkg::DP_RD_TOP;
              state_d   = S_RD_A;
            end
          end
          fls_pkg::CMD_GET_SCALAR: begin
            if (stat_i.empty) begin
              ctrl_o.op = fls_pkg::DP_UNDER;
            end else begin
              ctrl_o.op = fls_pkg::DP_SCAN_FIRST;
              state_d   = S_SCAN;
            end
          end
          default: begin
            if (stat_i.empty) begin
              ctrl_o.op = fls_pkg::DP_UNDER;
            end else begin
              ctrl_o.op = fls_pkg::DP_RD_TOP;
              state_d   = S_RD_A;
            end
          end
        endcase
      end
      S_RD_A: begin
        case (stat_i.cmd)
          fls_pkg::CMD_AND, fls_pkg::CMD_OR: begin
            ctrl_o.op = fls_pkg::DP_BIN_A;
            state_d   = S_RD_B;
          end
          fls_pkg::CMD_VERY: begin
            ctrl_o.op = fls_pkg::DP_MUL;
            state_d   = S_MUL;
          end
          fls_pkg::CMD_SOMEWHAT: begin
            ctrl_o.op = fls_pkg::DP_SQRT_INIT;
            state_d   = S_SQRT;
          end
          default: begin
            ctrl_o.op = fls_pkg::DP_NOT_WB;
            state_d   = S_DONE;
          end
        endcase
      end
      S_RD_B: begin
        ctrl_o.op = fls_pkg::DP_BIN_WB;
        state_d   = S_DONE;
      end
      S_MUL: begin
        ctrl_o.op = fls_pkg::DP_VERY_WB;
        state_d   = S_DONE;
      end
      S_SQRT: begin
        ctrl_o.op = fls_pkg::DP_SQRT_STEP;
        if (stat_i.sqrt_last) begin
          state_d = S_SQRT_WB;
        end
      end
      S_SQRT_WB: begin
        ctrl_o.op = fls_pkg::DP_SQRT_WB;
        state_d   = S_DONE;
      end
      S_SCAN: begin
        // Top entry closes the result
        if (stat_i.scan_top) begin
          ctrl_o.op = fls_pkg::DP_SCAN_TOP;
          state_d   = S_DONE;
        end else begin
          ctrl_o.op = fls_pkg::DP_SCAN_STEP;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          ctrl_o.load_out = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = ctrl_o.load_out | (out_valid_q & out_stall_i);

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/core/fuzzy_logic_stack_evaluator.sv =====
// Somewhat uses a 17-step bit-serial square root, and get-scalar does one
// stack RAM read per entry.
// Throughput: one request at a time; the next is taken once the result
// sits in the output register. Reset clears the depth and the handshakes;
// stack contents are not cleared.
module fuzzy_logic_stack_evaluator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fls_pkg::fls_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fls_pkg::fls_rsp_t out_rsp_o
);

  fls_pkg::fls_ctrl_t ctrl;
  fls_pkg::fls_stat_t stat;

  fls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  fls_datapath u_datapath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (in_req_i),
    .ctrl_i(ctrl),
    .stat_o(stat),
    .rsp_o (out_rsp_o)
  );

endmodule

// ===== rtl/core/fls_checker.sv =====
// Port-level checks for the fuzzy logic stack evaluator, bound to the top.
// Depends on fls_pkg.
module fls_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input fls_pkg::fls_rsp_t out_rsp_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  // One request at a time: stall rises right after a request is taken
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

  // Status code is one of the defined ones
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.status != 2'd3)
    else $error("bad status code");

  // Truth values never exceed 1.0
  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.value_out <= fls_pkg::Q_ONE)
    else $error("value above 1.0");

  // Errors carry a zero value
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != fls_pkg::ST_OK |-> out_rsp_o.value_out == '0)
    else $error("error result with nonzero value");

endmodule

bind fuzzy_logic_stack_evaluator fls_checker u_fls_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_rsp_o  (out_rsp_o)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for fuzzy_logic_stack_evaluator: directed probes, then random
// command sequences checked against an in-bench Q1.16 stack predictor.
// Depends on fls_pkg and the fuzzy_logic_stack_evaluator RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fls_pkg::*;

  localparam int unsigned TOTAL_ITEMS = 450;
  localparam int unsigned DRAIN_AT    = 250;
  localparam int unsigned HOLD_AT     = 120;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned NUM_PROBES  = 26;

  // One directed row: command, operand, repeat count and, where obvious, the typed result
  typedef struct packed {
    cmd_e             cmd;
    logic [VAL_W-1:0] operand;
    logic [4:0]       reps;
    logic             known;
    logic [VAL_W-1:0] value;
    status_e          status;
  } probe_t;

  localparam probe_t PROBES [NUM_PROBES] = '{
    // underflow on an empty stack, every operator
    '{CMD_GET_SCALAR, 17'h00000, 5'd1,  1'b1, Q_ZERO,    ST_UNDER},
    '{CMD_AND,        17'h00000, 5'd1,  1'b1, Q_ZERO,    ST_UNDER},
    '{CMD_OR,         17'h00000, 5'd1,  1'b1, Q_ZERO,    ST_UNDER},
    '{CMD_NOT,        17'h00000, 5'd1,  1'b1, Q_ZERO,    ST_UNDER},
    '{CMD_VERY,       17'h00000, 5'd1,  1'b1, Q_ZERO,    ST_UNDER},
    '{CMD_SOMEWHAT,   17'h00000, 5'd1,  1'b1, Q_ZERO,    ST_UNDER},
    // all-ones operand saturates to 1.0
    '{CMD_PUSH,       17'h1FFFF, 5'd1,  1'b1, Q_ONE,     ST_OK},
    // binary operators with a single entry, then with two
    '{CMD_AND,        17'h00000, 5'd1,  1'b1, Q_ZERO,    ST_UNDER},
    '{CMD_OR,         17'h00000, 5'd1,  1'b1, Q_ZERO,    ST_UNDER},
    '{CMD_PUSH,       17'h00000, 5'd1,  1'b1, Q_ZERO,    ST_OK},
    '{CMD_OR,         17'h00000, 5'd1,  1'b1, Q_ONE,     ST_OK},
    // hedges and not at 1.0 and 0.0, then pushes, operators and a clear
    '{CMD_SOMEWHAT,   17'h00000, 5'd1,  1'b1, Q_ONE,     ST_OK},
    '{CMD_VERY,       17'h00000, 5'd1,  1'b1, Q_ONE,     ST_OK},
    '{CMD_NOT,        17'h00000, 5'd1,  1'b1, Q_ZERO,    ST_OK},
    '{CMD_SOMEWHAT,   17'h00000, 5'd1,  1'b1, Q_ZERO,    ST_OK},
    '{CMD_PUSH,       17'h0AAAA, 5'd1,  1'b0, Q_ZERO,    ST_OK},
    '{CMD_PUSH,       17'h15555, 5'd1,  1'b1, Q_ONE,     ST_OK},
    '{CMD_GET_SCALAR, 17'h00000, 5'd1,  1'b0, Q_ZERO,    ST_OK},
    '{CMD_AND,        17'h00000, 5'd1,  1'b0, Q_ZERO,    ST_OK},
    '{CMD_VERY,       17'h00000, 5'd1,  1'b0, Q_ZERO,    ST_OK},
    '{CMD_CLEAR,      17'h1FFFF, 5'd1,  1'b1, Q_ZERO,    ST_OK},
    // fill the stack, then overflow it
    '{CMD_PUSH,       17'h0FFFF, 5'd16, 1'b1, 17'h0FFFF, ST_OK},
    '{CMD_PUSH,       17'h10000, 5'd1,  1'b1, Q_ZERO,    ST_OVER},
    '{CMD_GET_SCALAR, 17'h00000, 5'd1,  1'b0, Q_ZERO,    ST_OK},
    '{CMD_SOMEWHAT,   17'h00000, 5'd1,  1'b0, Q_ZERO,    ST_OK},
    '{CMD_CLEAR,      17'h00000, 5'd1,  1'b1, Q_ZERO,    ST_OK}
  };

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     out_stall = 1'b0;
  fls_req_t in_req    = '0;
  logic     in_stall_o;
  logic     out_valid_o;
  fls_rsp_t out_rsp_o;

  // Predictor state
  logic [VAL_W-1:0] truth_mem [STACK_DEPTH];
  int unsigned      stack_fill = 0;
  fls_rsp_t         pending_results [$];

  int unsigned sent_count   = 0;
  int unsigned results_seen = 0;
  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  int unsigned burst_left   = 0;
  int unsigned rx_mode, rx_span;
  bit          held_long    = 1'b0;
  fls_rsp_t    want;

  fuzzy_logic_stack_evaluator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("fuzzy_logic_stack_evaluator test failed");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    error_count++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Executes one request on the predictor stack and returns its result
  function automatic fls_rsp_t step_stack(input fls_req_t req);
    fls_rsp_t         rsp;
    logic [VAL_W-1:0] a, b, top;
    logic [63:0]      wide, trial;
    logic [VAL_W-1:0] root;
    rsp.value_out = Q_ZERO;
    rsp.status    = ST_OK;
    case (cmd_e'(req.command))
      CMD_CLEAR: begin
        stack_fill = 0;
      end
      CMD_PUSH: begin
        if (stack_fill >= STACK_DEPTH) begin
          rsp.status = ST_OVER;
        end else begin
          rsp.value_out = (req.operand > Q_ONE) ? Q_ONE : req.operand;
          truth_mem[stack_fill] = rsp.value_out;
          stack_fill++;
        end
      end
      CMD_AND, CMD_OR: begin
        if (stack_fill < 2) begin
          rsp.status = ST_UNDER;
        end else begin
          a = truth_mem[stack_fill-1];
          b = truth_mem[stack_fill-2];
          if (cmd_e'(req.command) == CMD_AND) rsp.value_out = (a < b) ? a : b;
          else rsp.value_out = (a > b) ? a : b;
          stack_fill--;
          truth_mem[stack_fill-1] = rsp.value_out;
        end
      end
      CMD_NOT, CMD_VERY, CMD_SOMEWHAT: begin
        if (stack_fill < 1) begin
          rsp.status = ST_UNDER;
        end else begin
          top = truth_mem[stack_fill-1];
          if (top > Q_ONE) top = Q_ONE;
          if (cmd_e'(req.command) == CMD_NOT) begin
            rsp.value_out = Q_ONE - top;
          end else if (cmd_e'(req.command) == CMD_VERY) begin
            wide = (64'(top) * 64'(top)) >> FRAC_W;
            rsp.value_out = wide[VAL_W-1:0];
          end else begin
            // floor(sqrt(top * 2^16)), one result bit at a time
            wide = 64'(top) << FRAC_W;
            root = '0;
            for (int k = VAL_W - 1; k >= 0; k--) begin
              trial = 64'(root | (VAL_W'(1) << k));
              if (trial * trial <= wide) root = root | (VAL_W'(1) << k);
            end
            rsp.value_out = root;
          end
          truth_mem[stack_fill-1] = rsp.value_out;
        end
      end
      default: begin
        // get scalar: min of complements below the top, then min with the top
        if (stack_fill < 1) begin
          rsp.status = ST_UNDER;
        end else begin
          rsp.value_out = Q_ONE;
          for (int k = 0; k + 1 < stack_fill; k++) begin
            a = Q_ONE - ((truth_mem[k] > Q_ONE) ? Q_ONE : truth_mem[k]);
            if (a < rsp.value_out) rsp.value_out = a;
          end
          top = truth_mem[stack_fill-1];
          if (top < rsp.value_out) rsp.value_out = top;
        end
      end
    endcase
    return rsp;
  endfunction

  function automatic logic [VAL_W-1:0] pick_truth();
    case ($urandom_range(0, 9))
      0:       return Q_ZERO;
      1:       return Q_ONE;
      2:       return Q_ONE - VAL_W'(1);
      3:       return VAL_W'($urandom_range(Q_ONE + 1, (1 << VAL_W) - 1));
      4:       return VAL_W'($urandom());
      default: return VAL_W'($urandom_range(0, Q_ONE));
    endcase
  endfunction

  // Sender bursts: random-length runs of back-to-back requests, random gaps between
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  // Offer one request, wait for it to be taken, record the expected result
  task automatic send_request(input cmd_e cmd, input logic [VAL_W-1:0] opnd,
                              input bit known = 1'b0, input fls_rsp_t typed = '0);
    fls_req_t req;
    fls_rsp_t predicted;
    req.command = cmd;
    req.operand = opnd;
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk_i); while (in_stall_o);
    predicted = step_stack(req);
    pending_results.push_back(known ? typed : predicted);
    sent_count++;
    pace();
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result value_out %h status %0d",
                             out_rsp_o.value_out, out_rsp_o.status));
      end else begin
        want = pending_results.pop_front();
        if (out_rsp_o.value_out !== want.value_out)
          flag_error($sformatf("result %0d value_out %h, want %h", results_seen,
                               out_rsp_o.value_out, want.value_out));
        if (out_rsp_o.status !== want.status)
          flag_error($sformatf("result %0d status %0d, want %0d", results_seen,
                               out_rsp_o.status, want.status));
      end
    end
  end

  // Receiver stall pattern, with one long hold-off so the block backs up
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held_long && results_seen >= HOLD_AT) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        rx_mode = $urandom_range(0, 3);
        rx_span = $urandom_range(4, 40);
        repeat (rx_span) begin
          case (rx_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(0, 1));
            2:       out_stall <= ($urandom_range(0, 4) == 0);
            default: out_stall <= ($urandom_range(0, 4) != 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // Stimulus
  initial begin
    fls_rsp_t    typed;
    int unsigned kind, n;
    bit          paused;
    paused = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed probes
    for (int r = 0; r < NUM_PROBES; r++) begin
      typed.value_out = PROBES[r].value;
      typed.status    = PROBES[r].status;
      repeat (PROBES[r].reps)
        send_request(PROBES[r].cmd, PROBES[r].operand, PROBES[r].known, typed);
    end

    // random command sequences, mostly well-formed expressions
    while (sent_count < TOTAL_ITEMS) begin
      if (!paused && sent_count >= DRAIN_AT) begin
        paused = 1'b1;
        drain_results();
      end
      kind = $urandom_range(0, 19);
      if (kind <= 12) begin
        n = $urandom_range(1, 5);
        repeat (n) send_request(CMD_PUSH, pick_truth());
        repeat ($urandom_range(1, n + 1))
          send_request(cmd_e'($urandom_range(CMD_AND, CMD_SOMEWHAT)), pick_truth());
        if ($urandom_range(0, 1) == 1) send_request(CMD_GET_SCALAR, pick_truth());
      end else if (kind <= 14) begin
        // fill to the top and push past it
        while (stack_fill < STACK_DEPTH) send_request(CMD_PUSH, pick_truth());
        repeat ($urandom_range(1, 2)) send_request(CMD_PUSH, pick_truth());
        send_request(CMD_GET_SCALAR, pick_truth());
        repeat ($urandom_range(1, 3))
          send_request(cmd_e'($urandom_range(CMD_AND, CMD_SOMEWHAT)), pick_truth());
        send_request(CMD_CLEAR, pick_truth());
      end else if (kind <= 17) begin
        repeat ($urandom_range(1, 4))
          send_request(cmd_e'($urandom_range(CMD_CLEAR, CMD_GET_SCALAR)), VAL_W'($urandom()));
      end else if (kind == 18) begin
        send_request(CMD_CLEAR, pick_truth());
      end else begin
        send_request(CMD_GET_SCALAR, pick_truth());
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("fuzzy_logic_stack_evaluator test passed");
    end else begin
      $display("fuzzy_logic_stack_evaluator test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/fls_pkg.sv
rtl/core/fls_ram.sv
rtl/core/fls_datapath.sv
rtl/core/fls_ctrl.sv
rtl/core/fuzzy_logic_stack_evaluator.sv
rtl/core/fls_checker.sv
sim/testbench.sv
